// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Request/response payloads, the cell command and the error codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam logic [1:0] KIND_PUSH     = 2'd0;
    localparam logic [1:0] KIND_POP_HEAD = 2'd1;
    localparam logic [1:0] KIND_POP_TAIL = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  priority_req;
        logic [15:0] tag;
    } t_req;

    typedef struct packed {
        logic        removed_valid;
        logic [15:0] removed_tag;
        logic [7:0]  removed_priority;
        logic        head_valid;
        logic [15:0] head_tag;
        logic [7:0]  head_priority;
        logic [4:0]  count;
        logic [1:0]  error;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  pri;
        logic [15:0] tag;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP_HEAD,
        OP_POP_TAIL
    } t_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_op    op;
        t_entry ent;
    } t_cmd;

endpackage
`default_nettype wire

// File: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on a push it keeps, takes the new entry or takes its left
// neighbor; on pops it takes its right neighbor or drops out at the tail.
// ----------------------------------------------------------------------------
module spq_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire spq_pkg::t_cmd   i_cmd,
    input  wire logic            i_left_valid,
    input  wire logic            i_left_ge,
    input  wire spq_pkg::t_entry i_left_ent,
    input  wire logic            i_right_valid,
    input  wire spq_pkg::t_entry i_right_ent,
    output logic                 o_valid,
    output logic                 o_ge,
    output spq_pkg::t_entry      o_ent
);

    logic            r_valid;
    logic            n_valid;
    spq_pkg::t_entry r_ent;
    spq_pkg::t_entry n_ent;

    // stays ahead of an incoming entry of equal or lower priority
    assign o_ge = r_valid && (r_ent.pri >= i_cmd.ent.pri);

    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        case (i_cmd.op)
            spq_pkg::OP_PUSH: begin
                if (!o_ge) begin
                    n_valid = r_valid | i_left_valid;
                    n_ent   = i_left_ge ? i_cmd.ent : i_left_ent;
                end
            end
            spq_pkg::OP_POP_HEAD: begin
                n_valid = i_right_valid;
                n_ent   = i_right_ent;
            end
            spq_pkg::OP_POP_TAIL: begin
                if (!i_right_valid) n_valid = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_valid = r_valid;
    assign o_ent   = r_ent;

endmodule
`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a chain of sorted cells
// Push inserts behind all entries of equal or higher priority; pops take the
// head or the tail. Each request yields one response.
// ----------------------------------------------------------------------------
//  channel   valid     stall     payload
//  request   i_valid   o_stall   i_req  (spq_pkg::t_req)
//  response  o_valid   i_stall   o_rsp  (spq_pkg::t_rsp)
//
//  One request per cycle unless stalled: all cells compare and shift in
//  parallel in the cycle the request is taken; its response is registered.
//  A new request is taken while a response waits, unless that response is
//  stalled; o_stall follows i_stall only while a response is held.
//  Reset (synchronous, active low) empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire spq_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_stall,
    output spq_pkg::t_rsp      o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic              [DEPTH-1:0] w_valid;
    logic              [DEPTH-1:0] w_ge;
    spq_pkg::t_entry               w_ent [DEPTH];

    spq_pkg::t_cmd   w_cmd;
    logic            w_accept;
    logic [1:0]      w_err;
    logic [IW-1:0]   w_tail_idx;
    spq_pkg::t_entry w_removed;
    logic            w_removed_valid;
    spq_pkg::t_entry w_head;
    spq_pkg::t_rsp   w_rsp;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;
    spq_pkg::t_rsp   r_rsp;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic            l_valid;
        logic            l_ge;
        spq_pkg::t_entry l_ent;
        logic            nb_valid;
        spq_pkg::t_entry nb_ent;

        if (g == 0) begin : g_first
            assign l_valid = 1'b1;
            assign l_ge    = 1'b1;
            assign l_ent   = w_cmd.ent;
        end else begin : g_mid
            assign l_valid = w_valid[g-1];
            assign l_ge    = w_ge[g-1];
            assign l_ent   = w_ent[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign nb_valid = 1'b0;
            assign nb_ent   = w_ent[g];
        end else begin : g_inner
            assign nb_valid = w_valid[g+1];
            assign nb_ent   = w_ent[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_valid  (l_valid),
            .i_left_ge     (l_ge),
            .i_left_ent    (l_ent),
            .i_right_valid (nb_valid),
            .i_right_ent   (nb_ent),
            .o_valid       (w_valid[g]),
            .o_ge          (w_ge[g]),
            .o_ent         (w_ent[g])
        );
    end

    assign w_tail_idx = IW'(r_count - CW'(1));

    always_comb begin
        w_cmd.ent.pri   = i_req.priority_req;
        w_cmd.ent.tag   = i_req.tag;
        w_cmd.op        = spq_pkg::OP_HOLD;
        w_err           = spq_pkg::ERR_OK;
        w_removed_valid = 1'b0;
        w_removed       = '0;
        n_count         = r_count;
        unique case (i_req.kind)
            spq_pkg::KIND_PUSH: begin
                if (r_count == FULL) begin
                    w_err = spq_pkg::ERR_FULL;
                end else begin
                    w_cmd.op = spq_pkg::OP_PUSH;
                    n_count  = r_count + CW'(1);
                end
            end
            spq_pkg::KIND_POP_HEAD, spq_pkg::KIND_POP_TAIL: begin
                if (r_count == '0) begin
                    w_err = spq_pkg::ERR_EMPTY;
                end else begin
                    w_removed_valid = 1'b1;
                    n_count         = r_count - CW'(1);
                    if (i_req.kind == spq_pkg::KIND_POP_HEAD) begin
                        w_cmd.op  = spq_pkg::OP_POP_HEAD;
                        w_removed = w_ent[0];
                    end else begin
                        w_cmd.op  = spq_pkg::OP_POP_TAIL;
                        w_removed = w_ent[w_tail_idx];
                    end
                end
            end
            default: ;
        endcase
        if (!w_accept) begin
            w_cmd.op = spq_pkg::OP_HOLD;
        end
    end

    // head after this request
    always_comb begin
        case (w_cmd.op)
            spq_pkg::OP_PUSH:     w_head = w_ge[0] ? w_ent[0] : w_cmd.ent;
            spq_pkg::OP_POP_HEAD: w_head = w_ent[1];
            default:              w_head = w_ent[0];
        endcase
    end

    always_comb begin
        w_rsp.removed_valid    = w_removed_valid;
        w_rsp.removed_tag      = w_removed.tag;
        w_rsp.removed_priority = w_removed.pri;
        w_rsp.head_valid       = (n_count != '0);
        w_rsp.head_tag         = w_rsp.head_valid ? w_head.tag : '0;
        w_rsp.head_priority    = w_rsp.head_valid ? w_head.pri : '0;
        w_rsp.count            = 5'(n_count);
        w_rsp.error            = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

`ifndef NO_ASSERTIONS
    // occupied cells match the fill count
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell occupancy differs from count");

    // head cell is never behind its neighbor
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[0] && w_valid[1]) |-> (w_ent[0].pri >= w_ent[1].pri))
        else $error("head out of order");

    // a dropped push means the queue was full
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_err == spq_pkg::ERR_FULL)) |=> (r_count == FULL))
        else $error("push dropped while not full");
`endif

endmodule
`default_nettype wire

// File: tb/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// Pushes and pops go through the valid/stall request channel with random gaps
// and back-pressure on both sides. A local sorted copy of the queue predicts
// each response not given by a directed row; all are compared field by field.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

    localparam int DEPTH = 16;
    localparam logic [1:0] KIND_NOP = 2'd3;   // unused code, queue left alone
    localparam int N_RANDOM    = 1225;
    localparam int SEGMENT     = 32;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        spq_pkg::t_req req;
        bit            typed;
        spq_pkg::t_rsp rsp;
    } t_vec;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    spq_pkg::t_req i_req   = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    spq_pkg::t_rsp o_rsp;

    // local copy of the queue, slot 0 is the head
    spq_pkg::t_entry q_slot [DEPTH];
    int              q_count = 0;

    spq_pkg::t_rsp pending_rsp [$];
    t_vec          directed [$];
    int            n_accepted = 0;
    int            n_mismatch = 0;
    int            cycle      = 0;
    bit            hold_done  = 1'b0;

    always #5 i_clk = ~i_clk;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_rsp)
    );

    function automatic spq_pkg::t_rsp queue_step(input spq_pkg::t_req req);
        spq_pkg::t_rsp rsp;
        int            pos;
        int            i;
        rsp = '0;
        rsp.error = spq_pkg::ERR_OK;
        case (req.kind)
            spq_pkg::KIND_PUSH: begin
                if (q_count >= DEPTH) begin
                    rsp.error = spq_pkg::ERR_FULL;
                end else begin
                    // behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < q_count && q_slot[pos].pri >= req.priority_req) pos++;
                    for (i = q_count; i > pos; i--) q_slot[i] = q_slot[i - 1];
                    q_slot[pos].pri = req.priority_req;
                    q_slot[pos].tag = req.tag;
                    q_count++;
                end
            end
            spq_pkg::KIND_POP_HEAD: begin
                if (q_count == 0) begin
                    rsp.error = spq_pkg::ERR_EMPTY;
                end else begin
                    rsp.removed_valid    = 1'b1;
                    rsp.removed_tag      = q_slot[0].tag;
                    rsp.removed_priority = q_slot[0].pri;
                    for (i = 1; i < q_count; i++) q_slot[i - 1] = q_slot[i];
                    q_count--;
                end
            end
            spq_pkg::KIND_POP_TAIL: begin
                if (q_count == 0) begin
                    rsp.error = spq_pkg::ERR_EMPTY;
                end else begin
                    q_count--;
                    rsp.removed_valid    = 1'b1;
                    rsp.removed_tag      = q_slot[q_count].tag;
                    rsp.removed_priority = q_slot[q_count].pri;
                end
            end
            default: ;
        endcase
        if (q_count > 0) begin
            rsp.head_valid    = 1'b1;
            rsp.head_tag      = q_slot[0].tag;
            rsp.head_priority = q_slot[0].pri;
        end
        rsp.count = 5'(q_count);
        return rsp;
    endfunction

    // response with nothing removed
    function automatic spq_pkg::t_rsp mk_rsp(input bit hv, input logic [15:0] htag,
                                             input logic [7:0] hpri, input logic [4:0] cnt,
                                             input logic [1:0] err);
        spq_pkg::t_rsp rsp;
        rsp = '0;
        rsp.head_valid    = hv;
        rsp.head_tag      = htag;
        rsp.head_priority = hpri;
        rsp.count         = cnt;
        rsp.error         = err;
        return rsp;
    endfunction

    function automatic void add_row(input logic [1:0] kind, input logic [7:0] pri,
                                    input logic [15:0] tag, input bit typed,
                                    input spq_pkg::t_rsp rsp);
        t_vec v;
        v.req.kind         = kind;
        v.req.priority_req = pri;
        v.req.tag          = tag;
        v.typed            = typed;
        v.rsp              = rsp;
        directed.push_back(v);
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic spq_pkg::t_req make_request(input int push_pct);
        spq_pkg::t_req req;
        int            r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            req.kind = KIND_NOP;
        end else if (r < 3 + push_pct) begin
            req.kind = spq_pkg::KIND_PUSH;
        end else begin
            req.kind = $urandom_range(0, 1) ? spq_pkg::KIND_POP_HEAD : spq_pkg::KIND_POP_TAIL;
        end
        // a narrow priority range makes plenty of ties
        case ($urandom_range(0, 9))
            0, 1:    req.priority_req = $urandom_range(0, 1) ? 8'hff : 8'h00;
            2, 3, 4: req.priority_req = 8'($urandom_range(0, 3));
            default: req.priority_req = 8'($urandom_range(0, 255));
        endcase
        req.tag = 16'($urandom_range(0, 65535));
        return req;
    endfunction

    task automatic send_request(input spq_pkg::t_req req, input bit typed,
                                input spq_pkg::t_rsp typed_rsp, input int gap);
        spq_pkg::t_rsp predicted;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = queue_step(req);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        n_accepted++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        spq_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected response %p", o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                check_field("removed_valid", 16'(want.removed_valid),
                            16'(o_rsp.removed_valid));
                check_field("removed_tag", want.removed_tag, o_rsp.removed_tag);
                check_field("removed_priority", 16'(want.removed_priority),
                            16'(o_rsp.removed_priority));
                check_field("head_valid", 16'(want.head_valid), 16'(o_rsp.head_valid));
                check_field("head_tag", want.head_tag, o_rsp.head_tag);
                check_field("head_priority", 16'(want.head_priority),
                            16'(o_rsp.head_priority));
                check_field("count", 16'(want.count), 16'(o_rsp.count));
                check_field("error", 16'(want.error), 16'(o_rsp.error));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // response side back-pressure, with one long hold so the queue backs up
    initial begin
        bit stall_val;
        int run;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                stall_val = 1'b1;
                run       = HOLD_CYCLES;
            end else if ((cycle / 512) % 4 == 3) begin
                stall_val = 1'b0;
                run       = 1;
            end else begin
                stall_val = ($urandom_range(0, 2) == 0);
                run       = stall_val ? pick_gap(1'b0) + 1 : $urandom_range(1, 6);
            end
            i_stall <= stall_val;
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        int push_pct;
        bit quiet;
        push_pct = 50;
        quiet    = 1'b0;

        add_row(spq_pkg::KIND_POP_HEAD, 8'h00, 16'h0000, 1'b1,
                mk_rsp(1'b0, 16'h0000, 8'h00, 5'd0, spq_pkg::ERR_EMPTY));
        add_row(spq_pkg::KIND_POP_TAIL, 8'hff, 16'hffff, 1'b1,
                mk_rsp(1'b0, 16'h0000, 8'h00, 5'd0, spq_pkg::ERR_EMPTY));
        add_row(KIND_NOP, 8'hff, 16'hffff, 1'b1,
                mk_rsp(1'b0, 16'h0000, 8'h00, 5'd0, spq_pkg::ERR_OK));
        add_row(spq_pkg::KIND_PUSH, 8'h00, 16'h0000, 1'b1,
                mk_rsp(1'b1, 16'h0000, 8'h00, 5'd1, spq_pkg::ERR_OK));
        add_row(spq_pkg::KIND_PUSH, 8'hff, 16'hffff, 1'b1,
                mk_rsp(1'b1, 16'hffff, 8'hff, 5'd2, spq_pkg::ERR_OK));
        // tie with the head queues behind it
        add_row(spq_pkg::KIND_PUSH, 8'hff, 16'h1234, 1'b1,
                mk_rsp(1'b1, 16'hffff, 8'hff, 5'd3, spq_pkg::ERR_OK));
        add_row(spq_pkg::KIND_PUSH, 8'h80, 16'haaaa, 1'b0, '0);
        add_row(spq_pkg::KIND_PUSH, 8'h80, 16'h5555, 1'b0, '0);
        add_row(KIND_NOP, 8'h5a, 16'ha5a5, 1'b0, '0);
        add_row(spq_pkg::KIND_POP_HEAD, 8'h00, 16'h0000, 1'b0, '0);
        add_row(spq_pkg::KIND_POP_TAIL, 8'h00, 16'h0000, 1'b0, '0);
        for (int k = 0; k < 13; k++)
            add_row(spq_pkg::KIND_PUSH, 8'(k * 37), 16'(16'h1000 + k), 1'b0, '0);
        // queue is full now: dropped
        add_row(spq_pkg::KIND_PUSH, 8'hff, 16'hbeef, 1'b0, '0);
        add_row(spq_pkg::KIND_POP_TAIL, 8'h00, 16'h0000, 1'b0, '0);
        add_row(spq_pkg::KIND_POP_HEAD, 8'h00, 16'h0000, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_request(directed[k].req, directed[k].typed, directed[k].rsp,
                         pick_gap(1'b0));

        for (int n = 0; n < N_RANDOM; n++) begin
            // push-heavy and pop-heavy stretches walk the queue between full and empty
            if (n % SEGMENT == 0) begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 25;
                    1:       push_pct = 45;
                    2:       push_pct = 70;
                    default: push_pct = 90;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            send_request(make_request(push_pct), 1'b0, '0, pick_gap(quiet));
        end
        i_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_mismatch == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
